/* rtl/mandatory_access_monitor_macros.svh */
// Assertion macros for the mandatory access monitor.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef MANDATORY_ACCESS_MONITOR_MACROS_SVH
`define MANDATORY_ACCESS_MONITOR_MACROS_SVH

`ifndef SYNTH
// Check that a property holds in the same cycle.
`define MAM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition in this cycle implies another one in the next cycle.
`define MAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MAM_ASSERT(lbl, prop, msg)
`define MAM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/mam_pkg.sv */
`default_nettype none

package mam_pkg;

	// Table sizes
	localparam int NUM_SUBJECTS = 16;
	localparam int NUM_OBJECTS  = 16;

	// Field widths
	localparam int ID_W    = 4;
	localparam int VALUE_W = 32;
	localparam int LEVEL_W = 2;
	localparam int CODE_W  = 2;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam int OBJ_IDX_W = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;

	// Operation codes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Security levels
	typedef enum logic [LEVEL_W-1:0] {
		LVL_LOW     = 2'd0,
		LVL_MEDIUM  = 2'd1,
		LVL_HIGH    = 2'd2,
		LVL_INVALID = 2'd3
	} level_t;

	// Result codes
	typedef enum logic [CODE_W-1:0] {
		RC_SUBJECT_MISSING = 2'd0,
		RC_OBJECT_MISSING  = 2'd1,
		RC_DENIED          = 2'd2,
		RC_GRANTED         = 2'd3
	} result_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SUBJECT_PRESENT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBJECT_LEVELS  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OBJECT_PRESENT  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OBJECT_LEVELS   = 4'd3;

	// Policy decision for one request
	typedef struct packed {
		result_t code;
		logic    grant_read;
		logic    grant_write;
	} decision_t;

endpackage

`default_nettype wire

/* rtl/mam_if.sv */
`default_nettype none

// Access request channel
interface mam_req_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [mam_pkg::ID_W-1:0]    subject_id;
	logic [mam_pkg::ID_W-1:0]    object_id;
	logic [mam_pkg::VALUE_W-1:0] write_value;

	modport source (
		output valid, operation, subject_id, object_id, write_value,
		input  ready
	);
	modport sink (
		input  valid, operation, subject_id, object_id, write_value,
		output ready
	);
endinterface

// Access result channel
interface mam_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mam_pkg::CODE_W-1:0]    result_code;
	logic [mam_pkg::VALUE_W-1:0]   read_value;

	modport source (
		output valid, result_code, read_value,
		input  ready
	);
	modport sink (
		input  valid, result_code, read_value,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/mandatory_access_monitor.sv */
// Mandatory access monitor: checks each request against the configured
// subject and object tables (present bit and two-bit level) and either grants
// it or returns why not. A granted read returns the object's stored value, a
// granted write replaces it. The block takes one request per cycle while the
// result channel does not stall it; each result passes through stage 1 and the
// output register before it goes valid on the result channel, and a stall there
// can hold it in stage 1, where the read of the object value memory lands. Object
// values read as zero until first written: one written bit per object, cleared
// by reset, stands in for clearing the memory, so the block is ready right after
// reset. Configuration is written through cfg_we, cfg_index and cfg_data; the
// user must do so only while no request is in flight; the block does not enforce it.
`default_nettype none

`include "mandatory_access_monitor_macros.svh"

module mandatory_access_monitor (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [mam_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mam_pkg::CFG_DATA_W-1:0]  cfg_data,
	mam_req_if.sink                              req,
	mam_rsp_if.source                            rsp
);
	import mam_pkg::*;

	// Configuration registers
	logic [NUM_SUBJECTS-1:0]         subj_present_q;
	logic [NUM_SUBJECTS*LEVEL_W-1:0] subj_levels_q;
	logic [NUM_OBJECTS-1:0]          obj_present_q;
	logic [NUM_OBJECTS*LEVEL_W-1:0]  obj_levels_q;

	// Object value memory and its written bits
	logic [VALUE_W-1:0]     obj_mem_q [NUM_OBJECTS];
	logic [NUM_OBJECTS-1:0] obj_written_q;

	// Stage 1: decision and memory read data
	logic               valid_s1;
	result_t            code_s1;
	logic               rd_s1;
	logic               written_s1;
	logic [VALUE_W-1:0] rdata_s1;

	// Output register
	logic               out_valid_q;
	result_t            out_code_q;
	logic [VALUE_W-1:0] out_value_q;

	decision_t              dec;
	logic                   req_acc;
	logic                   s1_adv;
	logic [OBJ_IDX_W-1:0]   obj_idx;

	assign obj_idx = req.object_id[OBJ_IDX_W-1:0];
	assign s1_adv  = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_adv;
	assign req_acc   = req.valid && req.ready;

	// Write configuration; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subj_present_q <= '0;
			subj_levels_q  <= '0;
			obj_present_q  <= '0;
			obj_levels_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SUBJECT_PRESENT: subj_present_q <= cfg_data[NUM_SUBJECTS-1:0];
				REG_SUBJECT_LEVELS:  subj_levels_q  <= cfg_data[NUM_SUBJECTS*LEVEL_W-1:0];
				REG_OBJECT_PRESENT:  obj_present_q  <= cfg_data[NUM_OBJECTS-1:0];
				REG_OBJECT_LEVELS:   obj_levels_q   <= cfg_data[NUM_OBJECTS*LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	mam_policy u_policy (
		.subject_present (subj_present_q),
		.subject_levels  (subj_levels_q),
		.object_present  (obj_present_q),
		.object_levels   (obj_levels_q),
		.operation       (req.operation),
		.subject_id      (req.subject_id),
		.object_id       (req.object_id),
		.decision        (dec)
	);

	// Read and write the object memory at acceptance; read data holds otherwise
	always_ff @(posedge clk) begin
		if (req_acc) begin
			rdata_s1 <= obj_mem_q[obj_idx];
			if (dec.grant_write) begin
				obj_mem_q[obj_idx] <= req.write_value;
			end
		end
	end

	// Mark objects once written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_written_q <= '0;
		end else if (req_acc && dec.grant_write) begin
			obj_written_q[obj_idx] <= 1'b1;
		end
	end

	// Advance stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			code_s1    <= dec.code;
			rd_s1      <= dec.grant_read;
			written_s1 <= obj_written_q[obj_idx];
		end
	end

	// Load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_code_q  <= code_s1;
			out_value_q <= (rd_s1 && written_s1) ? rdata_s1 : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_code = out_code_q;
	assign rsp.read_value  = out_value_q;

	// Only a granted read returns a value
	`MAM_ASSERT(a_value_only_granted, !out_valid_q || out_value_q == '0 || out_code_q == RC_GRANTED, "read value on an access that was not granted")
	// An accepted request occupies stage 1 next cycle
	`MAM_ASSERT_NEXT(a_accept_fills_s1, req_acc, valid_s1, "accepted request lost before stage 1")
	// A stalled stage 1 keeps its request
	`MAM_ASSERT_NEXT(a_s1_holds, valid_s1 && !s1_adv, valid_s1 && $stable(code_s1), "stage 1 dropped or changed while stalled")
	// Written bits never clear outside reset
	`MAM_ASSERT(a_written_sticky, (obj_written_q & $past(obj_written_q)) == $past(obj_written_q), "object written bit cleared")

endmodule

`default_nettype wire

/* rtl/mam_policy.sv */
`default_nettype none

// Presence and level checks for one request.
module mam_policy (
	input  wire logic [mam_pkg::NUM_SUBJECTS-1:0]                  subject_present,
	input  wire logic [mam_pkg::NUM_SUBJECTS*mam_pkg::LEVEL_W-1:0] subject_levels,
	input  wire logic [mam_pkg::NUM_OBJECTS-1:0]                   object_present,
	input  wire logic [mam_pkg::NUM_OBJECTS*mam_pkg::LEVEL_W-1:0]  object_levels,
	input  wire logic                                              operation,
	input  wire logic [mam_pkg::ID_W-1:0]                          subject_id,
	input  wire logic [mam_pkg::ID_W-1:0]                          object_id,
	output mam_pkg::decision_t                                     decision
);
	import mam_pkg::*;

	logic   subj_exists;
	logic   obj_exists;
	level_t subj_level;
	level_t obj_level;
	logic   allowed;

	// Look up presence; an index past the table counts as missing
	always_comb begin
		subj_exists = 1'b0;
		obj_exists  = 1'b0;
		subj_level  = LVL_INVALID;
		obj_level   = LVL_INVALID;
		for (int i = 0; i < NUM_SUBJECTS; i++) begin
			if (subject_id == ID_W'(i)) begin
				subj_exists = subject_present[i];
				subj_level  = level_t'(subject_levels[i*LEVEL_W +: LEVEL_W]);
			end
		end
		for (int i = 0; i < NUM_OBJECTS; i++) begin
			if (object_id == ID_W'(i)) begin
				obj_exists = object_present[i];
				obj_level  = level_t'(object_levels[i*LEVEL_W +: LEVEL_W]);
			end
		end
	end

	// Apply no read up and no write down; an invalid level denies everything
	always_comb begin
		if (subj_level == LVL_INVALID || obj_level == LVL_INVALID) begin
			allowed = 1'b0;
		end else if (operation == OP_READ) begin
			allowed = subj_level >= obj_level;
		end else begin
			allowed = subj_level <= obj_level;
		end
	end

	// Rank the outcome: missing subject first, then missing object
	always_comb begin
		decision.grant_read  = 1'b0;
		decision.grant_write = 1'b0;
		if (!subj_exists) begin
			decision.code = RC_SUBJECT_MISSING;
		end else if (!obj_exists) begin
			decision.code = RC_OBJECT_MISSING;
		end else if (!allowed) begin
			decision.code = RC_DENIED;
		end else begin
			decision.code        = RC_GRANTED;
			decision.grant_read  = (operation == OP_READ);
			decision.grant_write = (operation == OP_WRITE);
		end
	end

endmodule

`default_nettype wire
